### rtl/bfa_pkg.sv
// Shared types, constants and the command record of the bitmap frame allocator.
package bfa_pkg;

    localparam int FRAMES_DEF  = 4096;
    localparam int WORD_BITS   = 32;
    localparam int FRAME_W     = 12;
    localparam int COUNT_W     = 13;
    localparam int SUM_W       = 14;
    // Highest frame any command can reach is 4095 + 8191 - 1, so word index stays below 384.
    localparam int WORD_CAP    = 384;
    localparam int WORD_IDX_W  = 9;
    localparam int FRAME_REACH = 12286;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [COUNT_W-1:0] FRAMES_IN_USE_RST = 13'd4096;

    typedef enum logic [1:0] {
        MODE_USED  = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        K_IMM   = 2'd0,
        K_MARK  = 2'd1,
        K_QUERY = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        B_IDLE  = 2'd0,
        B_SWEEP = 2'd1,
        B_FLUSH = 2'd2
    } t_bstate;

    typedef struct packed {
        t_kind                  kind;
        logic                   set_used;
        logic                   imm_answer;
        logic [WORD_IDX_W-1:0]  first_word;
        logic [WORD_IDX_W-1:0]  last_word;
        logic [WORD_BITS-1:0]   first_mask;
        logic [WORD_BITS-1:0]   last_mask;
        logic [COUNT_W-1:0]     needed;
    } t_cmd;

endpackage

### rtl/bitmap_frame_allocator.sv
// Top level of the bitmap page frame allocator: front end, command queue and bitmap sweeper.
//
// Use: a command beat (i_mode, i_first_frame, i_frame_count) is taken at a rising edge where
// start is high and busy is low. Mode 0 marks a range of frames used, mode 1 marks it free,
// mode 2 asks whether at least i_frame_count free frames lie among the first frames_in_use
// frames; mode 3 does nothing. Every command yields exactly one result beat: o_done is high
// for one cycle with o_enough_free, which is only ever high for a satisfied query.
// The receiver cannot stall; results appear in command order. The user must write the
// frames_in_use via i_cfg_we / i_cfg_data only while idle; the block does not enforce it.
//
// Timing: the front end classifies a command in the cycle it is taken and parks it in a
// two-entry queue, so busy rises only when both entries are waiting. The sweeper then walks
// the covered bitmap words through one memory read port and one write port, one word per
// cycle, after the command is loaded in the idle state and before a flush state. Empty
// ranges, queries for zero frames, queries while frames_in_use is zero and mode 3 skip
// the walk, and their result shows in the cycle after the sweeper picks the command up.
// Reset clears the queue, the sweeper and a per-word valid flag, so the whole bitmap reads
// as free at once with no clearing pass; frames_in_use returns to 4096.
module bitmap_frame_allocator #(
    parameter int FRAMES = bfa_pkg::FRAMES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_mode,
    input  logic [bfa_pkg::FRAME_W-1:0] i_first_frame,
    input  logic [bfa_pkg::COUNT_W-1:0] i_frame_count,
    input  logic                        i_cfg_we,
    input  logic [bfa_pkg::COUNT_W-1:0] i_cfg_data,
    output logic                        o_done,
    output logic                        o_enough_free
);

    bfa_pkg::t_cmd front_cmd;
    bfa_pkg::t_cmd queue_cmd;
    logic          queue_valid;
    logic          queue_pop;

    // Classification is combinational; the queue captures it on the accepting edge.
    bfa_front #(
        .FRAMES(FRAMES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_mode       (i_mode),
        .i_first_frame(i_first_frame),
        .i_frame_count(i_frame_count),
        .o_cmd        (front_cmd)
    );

    bfa_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (start),
        .i_cmd  (front_cmd),
        .i_pop  (queue_pop),
        .o_full (busy),
        .o_valid(queue_valid),
        .o_cmd  (queue_cmd)
    );

    // The sweeper owns the bitmap memory and the result register.
    bfa_back #(
        .FRAMES(FRAMES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (queue_valid),
        .i_cmd        (queue_cmd),
        .o_pop        (queue_pop),
        .o_done       (o_done),
        .o_enough_free(o_enough_free)
    );

endmodule

### rtl/bfa_front.sv
// Front end: holds the frame limit register and turns each command into a word-range record.
module bfa_front #(
    parameter int FRAMES = bfa_pkg::FRAMES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bfa_pkg::COUNT_W-1:0] i_cfg_data,
    input  logic [1:0]                  i_mode,
    input  logic [bfa_pkg::FRAME_W-1:0] i_first_frame,
    input  logic [bfa_pkg::COUNT_W-1:0] i_frame_count,
    output bfa_pkg::t_cmd               o_cmd
);

    localparam int CLIP_I = (FRAMES < bfa_pkg::FRAME_REACH) ? FRAMES : bfa_pkg::FRAME_REACH;
    localparam logic [bfa_pkg::SUM_W-1:0] CLIP = bfa_pkg::SUM_W'(CLIP_I);

    logic [bfa_pkg::COUNT_W-1:0]  r_frames_in_use;
    logic [bfa_pkg::SUM_W-1:0]    range_end;
    logic [bfa_pkg::SUM_W-1:0]    stop;
    logic [bfa_pkg::SUM_W-1:0]    stop_last;
    logic [bfa_pkg::SUM_W-1:0]    limit;
    logic [bfa_pkg::SUM_W-1:0]    limit_last;
    logic                         range_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= bfa_pkg::FRAMES_IN_USE_RST;
        end else if (i_cfg_we) begin
            r_frames_in_use <= i_cfg_data;
        end
    end

    always_comb begin
        range_end   = {2'b00, i_first_frame} + {1'b0, i_frame_count};
        stop        = (range_end < CLIP) ? range_end : CLIP;
        stop_last   = stop - bfa_pkg::SUM_W'(1);
        range_empty = ({2'b00, i_first_frame} >= stop);
        limit       = ({1'b0, r_frames_in_use} < CLIP) ? {1'b0, r_frames_in_use} : CLIP;
        limit_last  = limit - bfa_pkg::SUM_W'(1);
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.needed     = i_frame_count;
        o_cmd.first_mask = '1;
        o_cmd.last_mask  = '1;
        unique case (bfa_pkg::t_mode'(i_mode)) inside
            bfa_pkg::MODE_USED, bfa_pkg::MODE_FREE: begin
                o_cmd.set_used   = (bfa_pkg::t_mode'(i_mode) == bfa_pkg::MODE_USED);
                o_cmd.kind       = range_empty ? bfa_pkg::K_IMM : bfa_pkg::K_MARK;
                o_cmd.first_word = {2'b00, i_first_frame[bfa_pkg::FRAME_W-1:5]};
                o_cmd.last_word  = stop_last[bfa_pkg::SUM_W-1:5];
                o_cmd.first_mask = {bfa_pkg::WORD_BITS{1'b1}} << i_first_frame[4:0];
                o_cmd.last_mask  = {bfa_pkg::WORD_BITS{1'b1}} >> (5'd31 - stop_last[4:0]);
            end
            bfa_pkg::MODE_QUERY: begin
                if (i_frame_count == '0) begin
                    o_cmd.kind       = bfa_pkg::K_IMM;
                    o_cmd.imm_answer = 1'b1;
                end else if (limit == '0) begin
                    o_cmd.kind = bfa_pkg::K_IMM;
                end else begin
                    o_cmd.kind      = bfa_pkg::K_QUERY;
                    o_cmd.last_word = limit_last[bfa_pkg::SUM_W-1:5];
                    o_cmd.last_mask = {bfa_pkg::WORD_BITS{1'b1}} >> (5'd31 - limit_last[4:0]);
                end
            end
            bfa_pkg::MODE_NONE: begin
                o_cmd.kind = bfa_pkg::K_IMM;
            end
            default: begin
                o_cmd.kind = bfa_pkg::K_IMM;
            end
        endcase
    end

endmodule

### rtl/bfa_queue.sv
// Two-entry command queue between the front end and the bitmap sweeper.
module bfa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bfa_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output bfa_pkg::t_cmd o_cmd
);

    localparam int PW = $clog2(bfa_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(bfa_pkg::QUEUE_DEPTH + 1);

    bfa_pkg::t_cmd   r_slot [bfa_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(bfa_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/bfa_back.sv
// Back end: sweeps the usage bitmap one word per cycle to mark ranges or count free frames.
module bfa_back #(
    parameter int FRAMES = bfa_pkg::FRAMES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  bfa_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_done,
    output logic          o_enough_free
);

    localparam int WORDS     = (FRAMES + bfa_pkg::WORD_BITS - 1) / bfa_pkg::WORD_BITS;
    localparam int MEM_WORDS = (WORDS < bfa_pkg::WORD_CAP) ? WORDS : bfa_pkg::WORD_CAP;
    localparam int AW        = $clog2((MEM_WORDS > 1) ? MEM_WORDS : 2);
    localparam int W         = bfa_pkg::WORD_BITS;
    localparam int CW        = bfa_pkg::COUNT_W;

    logic [W-1:0]        r_mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] r_valid;

    bfa_pkg::t_bstate    r_state;
    bfa_pkg::t_bstate    n_state;
    bfa_pkg::t_kind      r_kind;
    logic                r_used;
    logic [AW-1:0]       r_addr;
    logic [AW-1:0]       r_first;
    logic [AW-1:0]       r_last;
    logic [W-1:0]        r_fmask;
    logic [W-1:0]        r_lmask;
    logic [CW-1:0]       r_needed;
    logic [CW-1:0]       r_acc;

    logic                r_b_go;
    logic [AW-1:0]       r_b_addr;
    logic [W-1:0]        r_b_mask;
    logic [W-1:0]        r_rdata;
    logic                r_rvalid;

    logic                r_done;
    logic                r_answer;
    logic                n_done;
    logic                n_answer;

    logic                load;
    logic                issue;
    logic [W-1:0]        issue_mask;
    logic [W-1:0]        word_old;
    logic [W-1:0]        word_new;
    logic                wr_en;
    logic [5:0]          word_free;
    logic [CW:0]         free_now;
    logic                query_answer;

    assign o_done        = r_done;
    assign o_enough_free = r_answer;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bfa_pkg::B_IDLE: begin
                if (i_valid && i_cmd.kind != bfa_pkg::K_IMM) begin
                    n_state = bfa_pkg::B_SWEEP;
                end
            end
            bfa_pkg::B_SWEEP: begin
                if (r_addr == r_last) begin
                    n_state = bfa_pkg::B_FLUSH;
                end
            end
            bfa_pkg::B_FLUSH: n_state = bfa_pkg::B_IDLE;
            default:          n_state = bfa_pkg::B_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        o_pop    = 1'b0;
        load     = 1'b0;
        issue    = 1'b0;
        n_done   = 1'b0;
        n_answer = 1'b0;
        unique case (r_state)
            bfa_pkg::B_IDLE: begin
                o_pop = i_valid;
                load  = i_valid;
                if (i_valid && i_cmd.kind == bfa_pkg::K_IMM) begin
                    n_done   = 1'b1;
                    n_answer = i_cmd.imm_answer;
                end
            end
            bfa_pkg::B_SWEEP: issue = 1'b1;
            bfa_pkg::B_FLUSH: begin
                n_done   = 1'b1;
                n_answer = (r_kind == bfa_pkg::K_QUERY) && query_answer;
            end
            default: ;
        endcase
    end

    always_comb begin
        issue_mask = (r_addr == r_first) ? r_fmask : '1;
        if (r_addr == r_last) begin
            issue_mask = issue_mask & r_lmask;
        end
        word_old     = r_rvalid ? r_rdata : '0;
        word_new     = r_used ? (word_old | r_b_mask) : (word_old & ~r_b_mask);
        wr_en        = r_b_go && (r_kind == bfa_pkg::K_MARK);
        word_free    = 6'($countones(~word_old & r_b_mask));
        free_now     = {1'b0, r_acc} + {{(CW-5){1'b0}}, word_free};
        query_answer = (free_now >= {1'b0, r_needed});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bfa_pkg::B_IDLE;
            r_b_go   <= 1'b0;
            r_done   <= 1'b0;
            r_answer <= 1'b0;
            r_valid  <= '0;
        end else begin
            r_state  <= n_state;
            r_b_go   <= issue;
            r_done   <= n_done;
            r_answer <= n_answer;
            if (wr_en) begin
                r_valid[r_b_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= i_cmd.kind;
            r_used   <= i_cmd.set_used;
            r_addr   <= i_cmd.first_word[AW-1:0];
            r_first  <= i_cmd.first_word[AW-1:0];
            r_last   <= i_cmd.last_word[AW-1:0];
            r_fmask  <= i_cmd.first_mask;
            r_lmask  <= i_cmd.last_mask;
            r_needed <= i_cmd.needed;
            r_acc    <= '0;
        end else begin
            if (issue) begin
                r_addr <= r_addr + AW'(1);
            end
            if (r_b_go) begin
                r_acc <= free_now[CW-1:0];
            end
        end
        r_b_addr <= r_addr;
        r_b_mask <= issue_mask;
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rdata  <= r_mem[r_addr];
            r_rvalid <= r_valid[r_addr];
        end
        if (wr_en) begin
            r_mem[r_b_addr] <= word_new;
        end
    end

endmodule

### rtl/bfa_checker.sv
// Port-level checks for the bitmap frame allocator, bound to the top level.
module bfa_port_checks (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input logic o_enough_free
);

    // Reset leaves no result pending.
    a_no_done_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result beat straight after reset");

    // Reset empties the queue.
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy)
        else $error("busy straight after reset");

    // The answer bit is only meaningful, and only set, on a result beat.
    a_answer_on_done: assert property (@(posedge i_clk)
        o_enough_free |-> o_done)
        else $error("answer set without a result beat");

    // The queue can only fill up on a taken command.
    a_busy_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy rose without a command beat");

endmodule

bind bitmap_frame_allocator bfa_port_checks u_bfa_port_checks (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_enough_free(o_enough_free)
);
